/* src/irpc_pkg.sv */
// ----------------------------------------------------------------------------
// irpc_pkg
// Shared types, constants and the range lookup for the IR pair conditioner.
// ----------------------------------------------------------------------------
package irpc_pkg;

  localparam int unsigned SampleW   = 12;
  localparam int unsigned MmW       = 7;
  localparam int unsigned OffsetW   = 13;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 13;

  localparam int unsigned TablePoints = 7;
  localparam int unsigned SegW        = 3;
  // largest distance step between neighboring table points
  localparam int unsigned MmStepMax   = 10;
  localparam int unsigned StepW       = 4;

  localparam logic [SampleW-1:0] AdcMax = 12'd4095;

  localparam logic [SampleW-1:0] RearPts [TablePoints] =
    '{12'd159, 12'd206, 12'd251, 12'd784, 12'd1757, 12'd2138, 12'd2398};
  localparam logic [SampleW-1:0] FrontPts [TablePoints] =
    '{12'd175, 12'd253, 12'd996, 12'd1737, 12'd2470, 12'd2758, 12'd2946};
  localparam logic [MmW-1:0] DistPts [TablePoints] =
    '{7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70};

  localparam logic signed [OffsetW-1:0] RearOffsetRst    = 13'sd0;
  localparam logic [SampleW-1:0]        LostThresholdRst = 12'd3600;
  localparam logic [MmW-1:0]            TooCloseRst      = 7'd30;
  localparam logic [MmW-1:0]            TooFarRst        = 7'd55;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REAR_OFFSET    = 2'd0,
    CFG_LOST_THRESHOLD = 2'd1,
    CFG_TOO_CLOSE_MM   = 2'd2,
    CFG_TOO_FAR_MM     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FACE_LOST      = 2'd0,
    FACE_TOO_FAR   = 2'd1,
    FACE_TOO_CLOSE = 2'd2,
    FACE_OK        = 2'd3
  } face_e;

  typedef struct packed {
    logic signed [OffsetW-1:0] rear_offset;
    logic [SampleW-1:0]        lost_threshold;
    logic [MmW-1:0]            too_close_mm;
    logic [MmW-1:0]            too_far_mm;
  } cfg_t;

  // Piecewise-linear conversion; quotient found by comparing d*dm against k*span.
  function automatic logic [MmW-1:0] to_mm(input logic [SampleW-1:0] v,
                                           input logic is_front);
    logic [SegW-1:0]      seg;
    logic [SegW-1:0]      seg_lo;
    logic                 found;
    logic [SampleW-1:0]   lo;
    logic [SampleW-1:0]   hi;
    logic [SampleW-1:0]   span;
    logic [SampleW-1:0]   d;
    logic [MmW-1:0]       mlo;
    logic [MmW-1:0]       mhi;
    logic [MmW-1:0]       dm;
    logic [SampleW+MmW-1:0] num;
    logic [SampleW+MmW-1:0] lim;
    logic [StepW-1:0]     q;
    logic [MmW-1:0]       res;
    seg   = SegW'(TablePoints);
    found = 1'b0;
    for (int i = 0; i < TablePoints; i++) begin
      if (!found && v <= (is_front ? FrontPts[i] : RearPts[i])) begin
        seg   = SegW'(i);
        found = 1'b1;
      end
    end
    seg_lo = seg - SegW'(1);
    lo   = is_front ? FrontPts[seg_lo] : RearPts[seg_lo];
    hi   = is_front ? FrontPts[seg]    : RearPts[seg];
    mlo  = DistPts[seg_lo];
    mhi  = DistPts[seg];
    span = hi - lo;
    d    = v - lo;
    dm   = mhi - mlo;
    num  = (SampleW+MmW)'(d) * (SampleW+MmW)'(dm);
    q    = '0;
    for (int k = 1; k <= MmStepMax; k++) begin
      lim = (SampleW+MmW)'(k) * (SampleW+MmW)'(span);
      if (num >= lim) begin
        q = q + StepW'(1);
      end
    end
    if (seg == '0) begin
      res = DistPts[0];
    end else if (!found) begin
      res = DistPts[TablePoints-1];
    end else if (hi <= lo || mhi < mlo) begin
      res = mlo;
    end else begin
      res = mlo + MmW'(q);
    end
    return res;
  endfunction

endpackage

/* src/irpc_if.sv */
// ----------------------------------------------------------------------------
// irpc_if
// Valid/ready channels of the IR pair conditioner: sample pairs, results and
// register writes.
// ----------------------------------------------------------------------------
interface irpc_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] rear_sample;
  logic [11:0] front_sample;

  modport source (output valid, output rear_sample, output front_sample, input ready);
  modport sink   (input valid, input rear_sample, input front_sample, output ready);
endinterface

interface irpc_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] rear_filtered;
  logic [11:0] front_filtered;
  logic [6:0]  rear_distance_mm;
  logic [6:0]  front_distance_mm;
  logic [1:0]  face_state;
  logic        front_miss;
  logic        rear_miss;

  modport source (output valid, output rear_filtered, output front_filtered,
                  output rear_distance_mm, output front_distance_mm,
                  output face_state, output front_miss, output rear_miss,
                  input ready);
  modport sink   (input valid, input rear_filtered, input front_filtered,
                  input rear_distance_mm, input front_distance_mm,
                  input face_state, input front_miss, input rear_miss,
                  output ready);
endinterface

interface irpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/irpc_filter.sv */
// ----------------------------------------------------------------------------
// irpc_filter
// Smoothing filters for both channels; the filter registers also hold the
// transfer for the mapping stage.
// ----------------------------------------------------------------------------
module irpc_filter (
  input  logic         clk_i,
  input  logic         rst_ni,
  irpc_in_if.sink      in_if,
  output logic         smooth_valid_o,
  input  logic         smooth_ready_i,
  output logic [11:0]  rear_smooth_o,
  output logic [11:0]  front_smooth_o
);

  logic        vld_q, vld_d;
  logic        primed_q;
  logic [11:0] rear_q, rear_d;
  logic [11:0] front_q, front_d;
  logic        accept;

  // x/10 for x < 2^16 as (x * 0xCCCD) >> 19
  function automatic logic [11:0] blend(input logic [11:0] old_v, input logic [11:0] raw);
    logic [15:0] sum;
    logic [31:0] prod;
    sum  = ({4'd0, old_v} << 3) - {4'd0, old_v} + ({4'd0, raw} << 1) + {4'd0, raw};
    prod = 32'(sum) * 32'd52429;
    return prod[30:19];
  endfunction

  assign in_if.ready = !vld_q || smooth_ready_i;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    rear_d  = primed_q ? blend(rear_q, in_if.rear_sample)   : in_if.rear_sample;
    front_d = primed_q ? blend(front_q, in_if.front_sample) : in_if.front_sample;
    vld_d   = accept || (vld_q && !smooth_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= 1'b0;
      primed_q <= 1'b0;
      rear_q   <= '0;
      front_q  <= '0;
    end else begin
      vld_q <= vld_d;
      if (accept) begin
        primed_q <= 1'b1;
        rear_q   <= rear_d;
        front_q  <= front_d;
      end
    end
  end

  assign smooth_valid_o = vld_q;
  assign rear_smooth_o  = rear_q;
  assign front_smooth_o = front_q;

`ifndef SYNTHESIS
  a_primed_before_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> primed_q) else $error("filter output valid before first transfer");

  a_first_loads_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !primed_q) |=> (rear_q == $past(in_if.rear_sample) &&
                               front_q == $past(in_if.front_sample)))
    else $error("first pair did not load filters directly");
`endif

endmodule

/* src/irpc_map.sv */
// ----------------------------------------------------------------------------
// irpc_map
// Rear offset and clamp, millimetre lookup, lost flags and face class, into
// the result register.
// ----------------------------------------------------------------------------
module irpc_map (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  irpc_pkg::cfg_t cfg_i,
  input  logic           smooth_valid_i,
  output logic           smooth_ready_o,
  input  logic [11:0]    rear_smooth_i,
  input  logic [11:0]    front_smooth_i,
  irpc_out_if.source     out_if
);

  logic                vld_q;
  logic                load;
  logic signed [13:0]  adj;
  logic [11:0]         rfilt;
  logic [6:0]          rmm;
  logic [6:0]          fmm;
  logic                flost;
  logic                rlost;
  irpc_pkg::face_e     face;

  logic [11:0]         rfilt_q;
  logic [11:0]         ffilt_q;
  logic [6:0]          rmm_q;
  logic [6:0]          fmm_q;
  irpc_pkg::face_e     face_q;
  logic                flost_q;
  logic                rlost_q;

  assign smooth_ready_o = !vld_q || out_if.ready;
  assign load           = smooth_valid_i && smooth_ready_o;

  always_comb begin
    adj = $signed({2'b00, rear_smooth_i}) + 14'(cfg_i.rear_offset);
    if (adj < 0) begin
      rfilt = '0;
    end else if (adj > $signed({2'b00, irpc_pkg::AdcMax})) begin
      rfilt = irpc_pkg::AdcMax;
    end else begin
      rfilt = adj[11:0];
    end
    rmm   = irpc_pkg::to_mm(rfilt, 1'b0);
    fmm   = irpc_pkg::to_mm(front_smooth_i, 1'b1);
    flost = front_smooth_i >= cfg_i.lost_threshold;
    rlost = rfilt >= cfg_i.lost_threshold;
    if (flost) begin
      face = irpc_pkg::FACE_LOST;
    end else if (fmm > cfg_i.too_far_mm && rmm > cfg_i.too_far_mm) begin
      face = irpc_pkg::FACE_TOO_FAR;
    end else if (fmm < cfg_i.too_close_mm && rmm < cfg_i.too_close_mm) begin
      face = irpc_pkg::FACE_TOO_CLOSE;
    end else begin
      face = irpc_pkg::FACE_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (smooth_ready_o) begin
      vld_q <= smooth_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rfilt_q <= rfilt;
      ffilt_q <= front_smooth_i;
      rmm_q   <= rmm;
      fmm_q   <= fmm;
      face_q  <= face;
      flost_q <= flost;
      rlost_q <= rlost;
    end
  end

  assign out_if.valid             = vld_q;
  assign out_if.rear_filtered     = rfilt_q;
  assign out_if.front_filtered    = ffilt_q;
  assign out_if.rear_distance_mm  = rmm_q;
  assign out_if.front_distance_mm = fmm_q;
  assign out_if.face_state        = face_q;
  assign out_if.front_miss        = flost_q;
  assign out_if.rear_miss         = rlost_q;

`ifndef SYNTHESIS
  a_mm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (rmm_q >= 7'd10 && rmm_q <= 7'd70 && fmm_q >= 7'd10 && fmm_q <= 7'd70))
    else $error("distance outside table range");

  a_lost_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (flost_q == (face_q == irpc_pkg::FACE_LOST)))
    else $error("face class disagrees with front lost flag");
`endif

endmodule

/* src/ir_pair_range_conditioner.sv */
// ----------------------------------------------------------------------------
// ir_pair_range_conditioner
// Smooths rear/front IR readings, maps them to millimetres and classifies
// the face.
// ----------------------------------------------------------------------------
// One sample pair is taken per clock while the result channel is not
// stalled. The pair updates the smoothing filters when it is transferred,
// and the result register loads from the filter registers once it is free,
// so a result passes through the filter registers and then the result
// register before it is offered; back pressure on the result channel holds
// both stages. Registers are written through the configuration channel,
// which is always ready, and take effect on the next pair that the result register loads.
// ----------------------------------------------------------------------------
module ir_pair_range_conditioner (
  input  logic        clk_i,
  input  logic        rst_ni,
  irpc_in_if.sink     in_if,
  irpc_out_if.source  out_if,
  irpc_cfg_if.sink    cfg_if
);

  irpc_pkg::cfg_t cfg_q;
  logic           smooth_valid;
  logic           smooth_ready;
  logic [11:0]    rear_smooth;
  logic [11:0]    front_smooth;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rear_offset    <= irpc_pkg::RearOffsetRst;
      cfg_q.lost_threshold <= irpc_pkg::LostThresholdRst;
      cfg_q.too_close_mm   <= irpc_pkg::TooCloseRst;
      cfg_q.too_far_mm     <= irpc_pkg::TooFarRst;
    end else if (cfg_if.valid) begin
      unique case (irpc_pkg::cfg_idx_e'(cfg_if.index))
        irpc_pkg::CFG_REAR_OFFSET:    cfg_q.rear_offset    <= $signed(cfg_if.data);
        irpc_pkg::CFG_LOST_THRESHOLD: cfg_q.lost_threshold <= cfg_if.data[11:0];
        irpc_pkg::CFG_TOO_CLOSE_MM:   cfg_q.too_close_mm   <= cfg_if.data[6:0];
        irpc_pkg::CFG_TOO_FAR_MM:     cfg_q.too_far_mm     <= cfg_if.data[6:0];
        default: ;
      endcase
    end
  end

  irpc_filter u_filter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_if          (in_if),
    .smooth_valid_o (smooth_valid),
    .smooth_ready_i (smooth_ready),
    .rear_smooth_o  (rear_smooth),
    .front_smooth_o (front_smooth)
  );

  irpc_map u_map (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .smooth_valid_i (smooth_valid),
    .smooth_ready_o (smooth_ready),
    .rear_smooth_i  (rear_smooth),
    .front_smooth_i (front_smooth),
    .out_if         (out_if)
  );

endmodule
